@@ hdl/ipv4_receive_header_check_assert.svh @@
// Assertion macros for the IPv4 receive header check.
`ifndef IPV4_RECEIVE_HEADER_CHECK_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_CHECK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPV4RHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPV4RHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ipv4rhc_pkg.sv @@
// Types, constants and the verdict function of the IPv4 receive header check.
`default_nettype none

package ipv4rhc_pkg;

  localparam int MAX_FRAME_BYTES_DEFAULT = 1500;
  localparam int HANDLER_SLOTS_DEFAULT   = 8;
  localparam int TABLE_SLOTS             = 8;

  localparam logic [5:0]  HDR_MIN_BYTES = 6'd20;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Status codes
  localparam logic [2:0] ST_DELIVERED  = 3'd0;
  localparam logic [2:0] ST_HDR_ERROR  = 3'd1;
  localparam logic [2:0] ST_FRAGMENT   = 3'd2;
  localparam logic [2:0] ST_NOT_FOR_US = 3'd3;
  localparam logic [2:0] ST_NO_HANDLER = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd0;
  localparam logic [1:0] REG_SUBNET_MASK   = 2'd1;
  localparam logic [1:0] REG_IF_CONFIGURED = 2'd2;
  localparam logic [1:0] REG_PROTO_TABLE   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  handler_slot;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [7:0]  time_to_live;
    logic [5:0]  payload_offset;
    logic [15:0] body_length;
  } out_item_t;

  // Header summary of one finished frame.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [7:0]  first_byte;
    logic [15:0] dgram_length;
    logic [15:0] fragment;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
    logic [21:0] sum;
  } frame_t;

  function automatic out_item_t verdict(
    input frame_t      f,
    input logic [31:0] local_address,
    input logic [31:0] subnet_mask,
    input logic        filter_on,
    input logic [63:0] proto_table,
    input logic [3:0]  slots,
    input logic [15:0] max_frame
  );
    out_item_t   r;
    logic [5:0]  hl;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [31:0] dbc;
    logic        hdr_err;
    logic        found;
    logic [2:0]  slot;
    logic [7:0]  p;
    hl    = {f.first_byte[3:0], 2'b00};
    fold1 = {1'b0, f.sum[15:0]} + {11'b0, f.sum[21:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
    dbc   = (local_address & subnet_mask) | ~subnet_mask;
    hdr_err = (f.frame_len < 16'(HDR_MIN_BYTES)) || (f.frame_len > max_frame)
           || (f.first_byte[7:4] != IP_VERSION) || (hl < HDR_MIN_BYTES)
           || ({10'b0, hl} > f.dgram_length) || (f.dgram_length > f.frame_len)
           || (fold2 != {1'b0, COUNT_MAX});
    found = 1'b0;
    slot  = 3'd0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      p = proto_table[8*i +: 8];
      if (!found && (4'(i) < slots) && (p != 8'd0) && (p == f.protocol)) begin
        found = 1'b1;
        slot  = 3'(i);
      end
    end
    r.source_address      = f.source;
    r.destination_address = f.destination;
    r.protocol_number     = f.protocol;
    r.time_to_live        = f.ttl;
    r.payload_offset      = hl;
    r.body_length         = f.dgram_length - {10'b0, hl};
    r.handler_slot        = 3'd0;
    if (hdr_err) begin
      r = '0;
      r.status = ST_HDR_ERROR;
    end else if ((f.fragment & FRAG_MASK) != 16'd0) begin
      r.status = ST_FRAGMENT;
    end else if (filter_on && (f.destination != BCAST_ADDR) && (f.destination != dbc)
                 && (f.destination != local_address)) begin
      r.status = ST_NOT_FOR_US;
    end else if (!found) begin
      r.status = ST_NO_HANDLER;
    end else begin
      r.status       = ST_DELIVERED;
      r.handler_slot = slot;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ipv4_receive_header_check.sv @@
// IPv4 receive header check: top level with config registers and verdict stages.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   in       | in_valid / in_ready   | in_item  (one packet byte + last mark)
//   out      | out_valid / out_ready | out_item (verdict and header fields)
//   cfg      | cfg_write_enable      | cfg_index, cfg_write_data
//
// One byte per cycle while in_ready is high; each accepted byte is captured and added.
// After its last byte, a verdict passes through the frame summary register,
// then the verdict logic into the output register.
// A stalled output holds one result and one summary; in_ready drops only then.
// Synchronous reset clears the config registers, the capture state and both valid flags.
`default_nettype none
`include "ipv4_receive_header_check_assert.svh"

module ipv4_receive_header_check #(
  parameter int MAX_FRAME_BYTES = ipv4rhc_pkg::MAX_FRAME_BYTES_DEFAULT,
  parameter int HANDLER_SLOTS   = ipv4rhc_pkg::HANDLER_SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipv4rhc_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipv4rhc_pkg::out_item_t out_item,
  input  logic                  cfg_write_enable,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_write_data
);
  import ipv4rhc_pkg::*;

  logic [31:0] local_address;
  logic [31:0] subnet_mask;
  logic        interface_configured;
  logic [63:0] protocol_table;

  logic   in_accept;
  logic   snap_valid;
  logic   snap_advance;
  frame_t frame_next;
  frame_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address        <= '0;
      subnet_mask          <= '0;
      interface_configured <= 1'b0;
      protocol_table       <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_LOCAL_ADDRESS: local_address        <= cfg_write_data[31:0];
        REG_SUBNET_MASK:   subnet_mask          <= cfg_write_data[31:0];
        REG_IF_CONFIGURED: interface_configured <= cfg_write_data[0];
        REG_PROTO_TABLE:   protocol_table       <= cfg_write_data;
      endcase
    end
  end

  assign snap_advance = !out_valid || out_ready;
  assign in_ready     = !snap_valid || snap_advance;
  assign in_accept    = in_valid && in_ready;

  ipv4rhc_header_capture u_capture (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .item   (in_item),
    .frame  (frame_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept && in_item.last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_advance) begin
        snap_valid <= 1'b0;
      end
      if (snap_advance) begin
        out_valid <= snap_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_item.last_byte) begin
      snap <= frame_next;
    end
    if (snap_advance && snap_valid) begin
      out_item <= verdict(snap, local_address, subnet_mask, interface_configured,
                          protocol_table, 4'(HANDLER_SLOTS), 16'(MAX_FRAME_BYTES));
    end
  end

  `IPV4RHC_ASSERT_NOW(a_hdr_err_zero,
    out_valid && out_item.status == ST_HDR_ERROR,
    out_item.source_address == 32'd0 && out_item.body_length == 16'd0
      && out_item.handler_slot == 3'd0,
    "header error result carries fields")
  `IPV4RHC_ASSERT_NOW(a_slot_only_delivered,
    out_valid && out_item.status != ST_DELIVERED, out_item.handler_slot == 3'd0,
    "handler slot set on undelivered packet")
  `IPV4RHC_ASSERT_NEXT(a_last_fills_snap, in_accept && in_item.last_byte, snap_valid,
    "frame summary lost after last byte")
  `IPV4RHC_ASSERT_NOW(a_full_blocks_input, snap_valid && out_valid && !out_ready, !in_ready,
    "request taken with both stages full")

endmodule

`default_nettype wire

@@ hdl/ipv4rhc_header_capture.sv @@
// Per-byte header field capture and ones' complement accumulation.
`default_nettype none

module ipv4rhc_header_capture (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  ipv4rhc_pkg::in_item_t item,
  output ipv4rhc_pkg::frame_t   frame
);
  import ipv4rhc_pkg::*;

  logic [15:0] byte_count, byte_count_next;
  logic [21:0] checksum_sum, checksum_sum_next;
  logic [7:0]  first_header_byte, first_header_byte_next;
  logic [15:0] dgram_length_field, dgram_length_field_next;
  logic [15:0] fragment_field, fragment_field_next;
  logic [7:0]  captured_ttl, captured_ttl_next;
  logic [7:0]  captured_protocol, captured_protocol_next;
  logic [31:0] captured_source, captured_source_next;
  logic [31:0] captured_destination, captured_destination_next;
  logic [7:0]  pending_high_byte, pending_high_byte_next;
  logic [5:0]  hl_next;
  logic [7:0]  b;

  always_comb begin
    b = item.data_byte;
    first_header_byte_next    = (byte_count == 16'd0) ? b : first_header_byte;
    dgram_length_field_next   = dgram_length_field;
    fragment_field_next       = fragment_field;
    captured_ttl_next         = (byte_count == 16'd8) ? b : captured_ttl;
    captured_protocol_next    = (byte_count == 16'd9) ? b : captured_protocol;
    captured_source_next      = captured_source;
    captured_destination_next = captured_destination;
    pending_high_byte_next    = pending_high_byte;
    checksum_sum_next         = checksum_sum;
    if (byte_count == 16'd2) dgram_length_field_next[15:8] = b;
    if (byte_count == 16'd3) dgram_length_field_next[7:0]  = b;
    if (byte_count == 16'd6) fragment_field_next[15:8]     = b;
    if (byte_count == 16'd7) fragment_field_next[7:0]      = b;
    if (byte_count >= 16'd12 && byte_count <= 16'd15) begin
      captured_source_next = {captured_source[23:0], b};
    end
    if (byte_count >= 16'd16 && byte_count <= 16'd19) begin
      captured_destination_next = {captured_destination[23:0], b};
    end
    // header length comes from byte 0, which may be this very byte
    hl_next = {first_header_byte_next[3:0], 2'b00};
    if (byte_count < {10'b0, hl_next}) begin
      if (!byte_count[0]) begin
        pending_high_byte_next = b;
      end else begin
        checksum_sum_next = checksum_sum + {6'b0, pending_high_byte, b};
      end
    end
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  always_comb begin
    frame.frame_len    = byte_count_next;
    frame.first_byte   = first_header_byte_next;
    frame.dgram_length = dgram_length_field_next;
    frame.fragment     = fragment_field_next;
    frame.ttl          = captured_ttl_next;
    frame.protocol     = captured_protocol_next;
    frame.source       = captured_source_next;
    frame.destination  = captured_destination_next;
    frame.sum          = checksum_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      byte_count           <= '0;
      checksum_sum         <= '0;
      first_header_byte    <= '0;
      dgram_length_field   <= '0;
      fragment_field       <= '0;
      captured_ttl         <= '0;
      captured_protocol    <= '0;
      captured_source      <= '0;
      captured_destination <= '0;
      pending_high_byte    <= '0;
    end else if (accept) begin
      byte_count           <= byte_count_next;
      checksum_sum         <= checksum_sum_next;
      first_header_byte    <= first_header_byte_next;
      dgram_length_field   <= dgram_length_field_next;
      fragment_field       <= fragment_field_next;
      captured_ttl         <= captured_ttl_next;
      captured_protocol    <= captured_protocol_next;
      captured_source      <= captured_source_next;
      captured_destination <= captured_destination_next;
      pending_high_byte    <= pending_high_byte_next;
    end
  end

endmodule

`default_nettype wire
